[rtl/sclc_pkg.sv]
// Shared types, constants and state encodings of the scan cluster leg classifier.
package sclc_pkg;

  localparam int MAX_HITS     = 1024;
  localparam int CNT_W        = $clog2(MAX_HITS + 1);
  localparam int SUM_W        = 16 + $clog2(MAX_HITS) + 1;
  localparam int DIV_W        = SUM_W + (SUM_W % 2);
  localparam int DIV_STEPS    = DIV_W / 2;
  localparam int STEP_W       = $clog2(DIV_STEPS);
  localparam int HIT_TOTAL_W  = 11;
  localparam int NUM_W        = 10;
  localparam int PCT_SCALE    = 100;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GAP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_MAX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOV_MIN  = 2'd3;

  localparam logic [15:0] GAP_RESET      = 16'd200;
  localparam logic [15:0] SPAN_MIN_RESET = 16'd50;
  localparam logic [15:0] SPAN_MAX_RESET = 16'd250;
  localparam logic [6:0]  MOV_MIN_RESET  = 7'd75;

  localparam logic [STEP_W-1:0] PH_SQX  = STEP_W'(0);
  localparam logic [STEP_W-1:0] PH_SQY  = STEP_W'(1);
  localparam logic [STEP_W-1:0] PH_SQMN = STEP_W'(2);
  localparam logic [STEP_W-1:0] PH_SQMX = STEP_W'(3);
  localparam logic [STEP_W-1:0] PH_SPAN = STEP_W'(4);
  localparam logic [STEP_W-1:0] PH_LAST = STEP_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic [15:0] gap_threshold_mm;
    logic [15:0] leg_span_min_mm;
    logic [15:0] leg_span_max_mm;
    logic [6:0]  moving_percent_min;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] dyn;
    logic [15:0]      first_x;
    logic [15:0]      first_y;
    logic [15:0]      end_x;
    logic [15:0]      end_y;
    logic [NUM_W-1:0] num;
    logic             done;
  } rec_t;

  typedef struct packed {
    logic [15:0]            center_x;
    logic [15:0]            center_y;
    logic [HIT_TOTAL_W-1:0] hit_total;
    logic [6:0]             moving_percent;
    logic [32:0]            span_squared;
    logic                   is_leg;
    logic                   leg_moving;
    logic [NUM_W-1:0]       cluster_number;
    logic                   scan_done;
  } res_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL_X,
    F_MUL_Y,
    F_MUL_T,
    F_DEC
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_FIN
  } back_state_t;

endpackage

[rtl/sclc_front.sv]
// Front end: takes hits, tests the gap, accumulates the open cluster, queues closed ones.
module sclc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  sclc_pkg::cfg_t      cfg,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  in_hit_x,
  input  logic signed [15:0]  in_hit_y,
  input  logic                in_hit_dynamic,
  input  logic                in_last_hit,
  output logic                q_push,
  input  logic                q_full,
  output sclc_pkg::rec_t      q_rec
);

  sclc_pkg::front_state_t state_r, state_nxt;

  logic [15:0] hx_r, hx_nxt, hy_r, hy_nxt;
  logic        hd_r, hd_nxt, hl_r, hl_nxt;
  logic [33:0] d2x_r, d2x_nxt, d2y_r, d2y_nxt;
  logic [31:0] thr2_r, thr2_nxt;
  logic [15:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic [15:0] first_x_r, first_x_nxt, first_y_r, first_y_nxt;
  logic [sclc_pkg::SUM_W-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic [sclc_pkg::CNT_W-1:0] count_r, count_nxt, dyn_r, dyn_nxt;
  logic [sclc_pkg::NUM_W-1:0] num_r, num_nxt;
  logic        open_r, open_nxt;

  logic signed [16:0] dx, dy, mul_a;
  logic signed [33:0] mul_p;
  logic [sclc_pkg::SUM_W-1:0] hx_ext, hy_ext;
  logic [sclc_pkg::CNT_W-1:0] hd_ext;
  logic        gap, clu_full, need_push, dec_go;

  assign dx = {hx_r[15], hx_r} - {prev_x_r[15], prev_x_r};
  assign dy = {hy_r[15], hy_r} - {prev_y_r[15], prev_y_r};

  always_comb begin
    case (state_r)
      sclc_pkg::F_MUL_X: mul_a = dx;
      sclc_pkg::F_MUL_Y: mul_a = dy;
      sclc_pkg::F_MUL_T: mul_a = {1'b0, cfg.gap_threshold_mm};
      default:           mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_a;

  assign hx_ext   = {{(sclc_pkg::SUM_W-16){hx_r[15]}}, hx_r};
  assign hy_ext   = {{(sclc_pkg::SUM_W-16){hy_r[15]}}, hy_r};
  assign hd_ext   = sclc_pkg::CNT_W'(hd_r);
  assign gap      = ({1'b0, d2x_r} + {1'b0, d2y_r}) > {3'b000, thr2_r};
  assign clu_full = count_r >= sclc_pkg::CNT_W'(sclc_pkg::MAX_HITS);
  assign need_push = open_r ? (hl_r || gap || clu_full) : hl_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sclc_pkg::F_IDLE:  if (push) state_nxt = sclc_pkg::F_MUL_X;
      sclc_pkg::F_MUL_X: state_nxt = sclc_pkg::F_MUL_Y;
      sclc_pkg::F_MUL_Y: state_nxt = sclc_pkg::F_MUL_T;
      sclc_pkg::F_MUL_T: state_nxt = sclc_pkg::F_DEC;
      sclc_pkg::F_DEC:   if (!(need_push && q_full)) state_nxt = sclc_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full   = 1'b1;
    dec_go = 1'b0;
    unique case (state_r)
      sclc_pkg::F_IDLE: full = 1'b0;
      sclc_pkg::F_DEC:  dec_go = !(need_push && q_full);
      default: ;
    endcase
    q_push = dec_go && need_push;
  end

  // datapath
  always_comb begin
    hx_nxt      = hx_r;
    hy_nxt      = hy_r;
    hd_nxt      = hd_r;
    hl_nxt      = hl_r;
    d2x_nxt     = d2x_r;
    d2y_nxt     = d2y_r;
    thr2_nxt    = thr2_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    first_x_nxt = first_x_r;
    first_y_nxt = first_y_r;
    sum_x_nxt   = sum_x_r;
    sum_y_nxt   = sum_y_r;
    count_nxt   = count_r;
    dyn_nxt     = dyn_r;
    num_nxt     = num_r;
    open_nxt    = open_r;

    q_rec.sum_x   = sum_x_r;
    q_rec.sum_y   = sum_y_r;
    q_rec.count   = count_r;
    q_rec.dyn     = dyn_r;
    q_rec.first_x = first_x_r;
    q_rec.first_y = first_y_r;
    q_rec.end_x   = prev_x_r;
    q_rec.end_y   = prev_y_r;
    q_rec.num     = num_r;
    q_rec.done    = 1'b0;

    if (state_r == sclc_pkg::F_IDLE && push) begin
      hx_nxt = in_hit_x;
      hy_nxt = in_hit_y;
      hd_nxt = in_hit_dynamic;
      hl_nxt = in_last_hit;
    end
    if (state_r == sclc_pkg::F_MUL_X) d2x_nxt  = mul_p;
    if (state_r == sclc_pkg::F_MUL_Y) d2y_nxt  = mul_p;
    if (state_r == sclc_pkg::F_MUL_T) thr2_nxt = mul_p[31:0];

    if (dec_go) begin
      prev_x_nxt = hx_r;
      prev_y_nxt = hy_r;
      if (!open_r) begin
        // start of scan
        first_x_nxt = hx_r;
        first_y_nxt = hy_r;
        sum_x_nxt   = hx_ext;
        sum_y_nxt   = hy_ext;
        count_nxt   = sclc_pkg::CNT_W'(1);
        dyn_nxt     = hd_ext;
        num_nxt     = '0;
        q_rec.sum_x   = hx_ext;
        q_rec.sum_y   = hy_ext;
        q_rec.count   = sclc_pkg::CNT_W'(1);
        q_rec.dyn     = hd_ext;
        q_rec.first_x = hx_r;
        q_rec.first_y = hy_r;
        q_rec.end_x   = hx_r;
        q_rec.end_y   = hy_r;
        q_rec.num     = '0;
        q_rec.done    = 1'b1;
        if (hl_r) begin
          num_nxt = sclc_pkg::NUM_W'(1);
        end else begin
          open_nxt = 1'b1;
        end
      end else if (hl_r) begin
        open_nxt   = 1'b0;
        num_nxt    = num_r + 1'b1;
        q_rec.done = 1'b1;
        if (!clu_full) begin
          q_rec.sum_x = sum_x_r + hx_ext;
          q_rec.sum_y = sum_y_r + hy_ext;
          q_rec.count = count_r + 1'b1;
          q_rec.dyn   = dyn_r + hd_ext;
          q_rec.end_x = hx_r;
          q_rec.end_y = hy_r;
        end
      end else if (gap || clu_full) begin
        num_nxt     = num_r + 1'b1;
        first_x_nxt = hx_r;
        first_y_nxt = hy_r;
        sum_x_nxt   = hx_ext;
        sum_y_nxt   = hy_ext;
        count_nxt   = sclc_pkg::CNT_W'(1);
        dyn_nxt     = hd_ext;
      end else begin
        sum_x_nxt = sum_x_r + hx_ext;
        sum_y_nxt = sum_y_r + hy_ext;
        count_nxt = count_r + 1'b1;
        dyn_nxt   = dyn_r + hd_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sclc_pkg::F_IDLE;
      open_r  <= 1'b0;
      num_r   <= '0;
    end else begin
      state_r <= state_nxt;
      open_r  <= open_nxt;
      num_r   <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hx_r      <= hx_nxt;
    hy_r      <= hy_nxt;
    hd_r      <= hd_nxt;
    hl_r      <= hl_nxt;
    d2x_r     <= d2x_nxt;
    d2y_r     <= d2y_nxt;
    thr2_r    <= thr2_nxt;
    prev_x_r  <= prev_x_nxt;
    prev_y_r  <= prev_y_nxt;
    first_x_r <= first_x_nxt;
    first_y_r <= first_y_nxt;
    sum_x_r   <= sum_x_nxt;
    sum_y_r   <= sum_y_nxt;
    count_r   <= count_nxt;
    dyn_r     <= dyn_nxt;
  end

endmodule

[rtl/sclc_queue.sv]
// Two-entry queue of closed cluster records between front and back end.
module sclc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  sclc_pkg::rec_t din,
  input  logic           pop,
  output logic           empty,
  output sclc_pkg::rec_t dout
);

  sclc_pkg::rec_t mem_r [sclc_pkg::QDEPTH];
  logic [sclc_pkg::QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [sclc_pkg::QPTR_W:0]   cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = cnt_r == (sclc_pkg::QPTR_W+1)'(sclc_pkg::QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= din;
  end

endmodule

[rtl/sclc_back.sv]
// Back end: centroid and percentage division, span and leg tests, result register.
module sclc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  sclc_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  sclc_pkg::rec_t q_rec,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output sclc_pkg::res_t res
);

  localparam int CW = sclc_pkg::CNT_W;
  localparam int DW = sclc_pkg::DIV_W;

  function automatic logic [CW+DW-1:0] div_step(input logic [CW-1:0] r,
                                                input logic [DW-1:0] q,
                                                input logic [CW-1:0] d);
    logic [CW:0] t;
    logic [CW:0] diff;
    logic        qb;
    t    = {r, q[DW-1]};
    diff = t - {1'b0, d};
    qb   = t >= {1'b0, d};
    return {(qb ? diff[CW-1:0] : t[CW-1:0]), q[DW-2:0], qb};
  endfunction

  sclc_pkg::back_state_t state_r, state_nxt;

  logic [sclc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [DW-1:0] qx_r, qx_nxt, qy_r, qy_nxt, qp_r, qp_nxt;
  logic [CW-1:0] rx_r, rx_nxt, ry_r, ry_nxt, rp_r, rp_nxt;
  logic [CW-1:0] div_r, div_nxt;
  logic          negx_r, negx_nxt, negy_r, negy_nxt;
  logic signed [16:0] sdx_r, sdx_nxt, sdy_r, sdy_nxt;
  logic [33:0]   sx2_r, sx2_nxt, sy2_r, sy2_nxt;
  logic [31:0]   mn2_r, mn2_nxt, mx2_r, mx2_nxt;
  logic [34:0]   span_r, span_nxt;
  logic [sclc_pkg::NUM_W-1:0] num_r, num_nxt;
  logic          done_r, done_nxt;
  sclc_pkg::res_t res_r, res_nxt;
  logic          ovalid_r, ovalid_nxt;

  logic signed [16:0] mul_a;
  logic signed [33:0] mul_p;
  logic [sclc_pkg::SUM_W-1:0] magx, magy;
  logic [CW+DW-1:0] sx1, sx2s, sy1, sy2s, sp1, sp2s;
  logic [DW-1:0] cx, cy;
  logic [6:0]    pct;
  logic          leg, load, finish, out_free;

  assign out_free = !ovalid_r || pop;

  always_comb begin
    case (step_r)
      sclc_pkg::PH_SQX:  mul_a = sdx_r;
      sclc_pkg::PH_SQY:  mul_a = sdy_r;
      sclc_pkg::PH_SQMN: mul_a = {1'b0, cfg.leg_span_min_mm};
      sclc_pkg::PH_SQMX: mul_a = {1'b0, cfg.leg_span_max_mm};
      default:           mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_a;

  assign magx = q_rec.sum_x[sclc_pkg::SUM_W-1] ? (~q_rec.sum_x + 1'b1) : q_rec.sum_x;
  assign magy = q_rec.sum_y[sclc_pkg::SUM_W-1] ? (~q_rec.sum_y + 1'b1) : q_rec.sum_y;

  always_comb begin
    sx1  = div_step(rx_r, qx_r, div_r);
    sx2s = div_step(sx1[CW+DW-1:DW], sx1[DW-1:0], div_r);
    sy1  = div_step(ry_r, qy_r, div_r);
    sy2s = div_step(sy1[CW+DW-1:DW], sy1[DW-1:0], div_r);
    sp1  = div_step(rp_r, qp_r, div_r);
    sp2s = div_step(sp1[CW+DW-1:DW], sp1[DW-1:0], div_r);
  end

  assign cx  = negx_r ? (~qx_r + 1'b1) : qx_r;
  assign cy  = negy_r ? (~qy_r + 1'b1) : qy_r;
  assign pct = qp_r[6:0];
  assign leg = (span_r > {3'b000, mn2_r}) && (span_r < {3'b000, mx2_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sclc_pkg::B_IDLE: if (!q_empty) state_nxt = sclc_pkg::B_RUN;
      sclc_pkg::B_RUN:  if (step_r == sclc_pkg::PH_LAST) state_nxt = sclc_pkg::B_FIN;
      sclc_pkg::B_FIN:  if (out_free) state_nxt = sclc_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    load   = 1'b0;
    finish = 1'b0;
    unique case (state_r)
      sclc_pkg::B_IDLE: load = !q_empty;
      sclc_pkg::B_FIN:  finish = out_free;
      default: ;
    endcase
    q_pop = load;
    empty = !ovalid_r;
    res   = res_r;
  end

  // datapath
  always_comb begin
    step_nxt = step_r;
    qx_nxt   = qx_r;
    qy_nxt   = qy_r;
    qp_nxt   = qp_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    rp_nxt   = rp_r;
    div_nxt  = div_r;
    negx_nxt = negx_r;
    negy_nxt = negy_r;
    sdx_nxt  = sdx_r;
    sdy_nxt  = sdy_r;
    sx2_nxt  = sx2_r;
    sy2_nxt  = sy2_r;
    mn2_nxt  = mn2_r;
    mx2_nxt  = mx2_r;
    span_nxt = span_r;
    num_nxt  = num_r;
    done_nxt = done_r;
    res_nxt  = res_r;
    ovalid_nxt = ovalid_r && !pop;

    if (load) begin
      step_nxt = '0;
      negx_nxt = q_rec.sum_x[sclc_pkg::SUM_W-1];
      negy_nxt = q_rec.sum_y[sclc_pkg::SUM_W-1];
      qx_nxt   = DW'(magx);
      qy_nxt   = DW'(magy);
      qp_nxt   = DW'(q_rec.dyn) * DW'(sclc_pkg::PCT_SCALE);
      rx_nxt   = '0;
      ry_nxt   = '0;
      rp_nxt   = '0;
      div_nxt  = q_rec.count;
      sdx_nxt  = {q_rec.first_x[15], q_rec.first_x} - {q_rec.end_x[15], q_rec.end_x};
      sdy_nxt  = {q_rec.first_y[15], q_rec.first_y} - {q_rec.end_y[15], q_rec.end_y};
      num_nxt  = q_rec.num;
      done_nxt = q_rec.done;
    end

    if (state_r == sclc_pkg::B_RUN) begin
      step_nxt = step_r + 1'b1;
      {rx_nxt, qx_nxt} = sx2s;
      {ry_nxt, qy_nxt} = sy2s;
      {rp_nxt, qp_nxt} = sp2s;
      case (step_r)
        sclc_pkg::PH_SQX:  sx2_nxt  = mul_p;
        sclc_pkg::PH_SQY:  sy2_nxt  = mul_p;
        sclc_pkg::PH_SQMN: mn2_nxt  = mul_p[31:0];
        sclc_pkg::PH_SQMX: mx2_nxt  = mul_p[31:0];
        sclc_pkg::PH_SPAN: span_nxt = {1'b0, sx2_r} + {1'b0, sy2_r};
        default: ;
      endcase
    end

    if (finish) begin
      ovalid_nxt             = 1'b1;
      res_nxt.center_x       = cx[15:0];
      res_nxt.center_y       = cy[15:0];
      res_nxt.hit_total      = sclc_pkg::HIT_TOTAL_W'(div_r);
      res_nxt.moving_percent = pct;
      res_nxt.span_squared   = span_r[32:0];
      res_nxt.is_leg         = leg;
      res_nxt.leg_moving     = leg && (pct >= cfg.moving_percent_min);
      res_nxt.cluster_number = num_r;
      res_nxt.scan_done      = done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sclc_pkg::B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    qp_r   <= qp_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    rp_r   <= rp_nxt;
    div_r  <= div_nxt;
    negx_r <= negx_nxt;
    negy_r <= negy_nxt;
    sdx_r  <= sdx_nxt;
    sdy_r  <= sdy_nxt;
    sx2_r  <= sx2_nxt;
    sy2_r  <= sy2_nxt;
    mn2_r  <= mn2_nxt;
    mx2_r  <= mx2_nxt;
    span_r <= span_nxt;
    num_r  <= num_nxt;
    done_r <= done_nxt;
    res_r  <= res_nxt;
  end

endmodule

[rtl/scan_cluster_leg_classifier_core.sv]
// Top level of the scan cluster leg classifier: configuration registers and the
// front end, queue and back end.
//
// Hits enter through a queue-style port (push/full) and closed clusters leave
// through another (empty/pop). The front end takes each hit in F_IDLE; then in
// F_MUL_X, F_MUL_Y and F_MUL_T a single shared 17x17 multiplier forms the two
// squared coordinate differences and the squared gap threshold before the gap
// decision in F_DEC, which waits while the queue is full. A closed cluster goes
// into a two-entry queue; the back end then runs a restoring divider retiring
// two quotient bits per cycle for both centroid coordinates and the dynamic
// percentage, while a second shared multiplier forms the span and the leg
// limits. The front end takes no new hit until it has decided on the last one,
// and the back end takes no new cluster until it has finished the last one. The
// result register lets the back end finish the next cluster while the current
// one waits to be popped. Configuration writes are always ready and should only
// be issued while the block is idle.
module scan_cluster_leg_classifier_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [15:0]                   in_hit_x,
  input  logic signed [15:0]                   in_hit_y,
  input  logic                                 in_hit_dynamic,
  input  logic                                 in_last_hit,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [15:0]                   out_center_x,
  output logic signed [15:0]                   out_center_y,
  output logic [sclc_pkg::HIT_TOTAL_W-1:0]     out_hit_total,
  output logic [6:0]                           out_moving_percent,
  output logic [32:0]                          out_span_squared,
  output logic                                 out_is_leg,
  output logic                                 out_leg_moving,
  output logic [sclc_pkg::NUM_W-1:0]           out_cluster_number,
  output logic                                 out_scan_done,
  input  logic                                 valid,
  output logic                                 ready,
  input  logic [sclc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [15:0]                          cfg_data
);

  sclc_pkg::cfg_t cfg_r, cfg_nxt;
  sclc_pkg::rec_t f_rec, q_rec;
  sclc_pkg::res_t res;
  logic q_push, q_full, q_pop, q_empty;

  assign ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (valid) begin
      unique case (cfg_index)
        sclc_pkg::REG_GAP:      cfg_nxt.gap_threshold_mm   = cfg_data;
        sclc_pkg::REG_SPAN_MIN: cfg_nxt.leg_span_min_mm    = cfg_data;
        sclc_pkg::REG_SPAN_MAX: cfg_nxt.leg_span_max_mm    = cfg_data;
        sclc_pkg::REG_MOV_MIN:  cfg_nxt.moving_percent_min = cfg_data[6:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_threshold_mm   <= sclc_pkg::GAP_RESET;
      cfg_r.leg_span_min_mm    <= sclc_pkg::SPAN_MIN_RESET;
      cfg_r.leg_span_max_mm    <= sclc_pkg::SPAN_MAX_RESET;
      cfg_r.moving_percent_min <= sclc_pkg::MOV_MIN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  sclc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .push           (push),
    .full           (full),
    .in_hit_x       (in_hit_x),
    .in_hit_y       (in_hit_y),
    .in_hit_dynamic (in_hit_dynamic),
    .in_last_hit    (in_last_hit),
    .q_push         (q_push),
    .q_full         (q_full),
    .q_rec          (f_rec)
  );

  sclc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .din   (f_rec),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_rec)
  );

  sclc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_rec   (q_rec),
    .q_pop   (q_pop),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign out_center_x       = res.center_x;
  assign out_center_y       = res.center_y;
  assign out_hit_total      = res.hit_total;
  assign out_moving_percent = res.moving_percent;
  assign out_span_squared   = res.span_squared;
  assign out_is_leg         = res.is_leg;
  assign out_leg_moving     = res.leg_moving;
  assign out_cluster_number = res.cluster_number;
  assign out_scan_done      = res.scan_done;

endmodule
